// ===== rtl/ed2_pkg.sv =====
package ed2_pkg;

  // square root: two result bits per stage
  localparam int SQ_STEPS  = 32;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = SQ_STEPS / SQ_PER;

  // restoring divider: quotient bits 30..0, four per stage
  localparam int DV_STEPS  = 31;
  localparam int DV_PER    = 4;
  localparam int DV_STAGES = (DV_STEPS + DV_PER - 1) / DV_PER;

  // prep, square, sum, root, divide, sign/select
  localparam int VEC_LAT = 3 + SQ_STAGES + DV_STAGES + 1;

  localparam logic [16:0]        THR_RESET = 17'd1;
  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic [30:0]        ONE_Q30_U = 31'h4000_0000;

  typedef struct packed {
    logic [63:0] rad;
    logic [32:0] rem;
    logic [31:0] root;
  } sq_st_t;

  typedef struct packed {
    logic [31:0] n;
    logic [31:0] rem_a;
    logic [31:0] rem_b;
    logic        nb_a;
    logic        nb_b;
    logic [30:0] q_a;
    logic [30:0] q_b;
  } dv_st_t;

  typedef struct packed {
    logic axis;   // use the axis unit vector
    logic neg_a;  // first component negative
  } vec_flags_t;

  // one bit of floor(sqrt)
  function automatic sq_st_t sq_step(input sq_st_t s);
    sq_st_t      o;
    logic [34:0] rem2;
    logic [34:0] trial;
    rem2  = {s.rem, s.rad[63:62]};
    trial = {1'b0, s.root, 2'b01};
    o.rad = {s.rad[61:0], 2'b00};
    if (rem2 >= trial) begin
      o.rem  = 33'(rem2 - trial);
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem  = rem2[32:0];
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_st_t sq_stage(input sq_st_t s);
    sq_st_t o;
    o = s;
    for (int j = 0; j < SQ_PER; j++) begin
      o = sq_step(o);
    end
    return o;
  endfunction

  // one quotient bit for both numerators
  function automatic dv_st_t dv_step(input dv_st_t s);
    dv_st_t      o;
    logic [32:0] ra;
    logic [32:0] rb;
    o      = s;
    ra     = {s.rem_a, s.nb_a};
    rb     = {s.rem_b, s.nb_b};
    o.nb_a = 1'b0;
    o.nb_b = 1'b0;
    if (ra >= {1'b0, s.n}) begin
      o.rem_a = 32'(ra - {1'b0, s.n});
      o.q_a   = {s.q_a[29:0], 1'b1};
    end else begin
      o.rem_a = ra[31:0];
      o.q_a   = {s.q_a[29:0], 1'b0};
    end
    if (rb >= {1'b0, s.n}) begin
      o.rem_b = 32'(rb - {1'b0, s.n});
      o.q_b   = {s.q_b[29:0], 1'b1};
    end else begin
      o.rem_b = rb[31:0];
      o.q_b   = {s.q_b[29:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_st_t dv_stage(input dv_st_t s, input int base);
    dv_st_t o;
    o = s;
    for (int j = 0; j < DV_PER; j++) begin
      if (base + j < DV_STEPS) begin
        o = dv_step(o);
      end
    end
    return o;
  endfunction

endpackage

// ===== rtl/ed2_isqrt.sv =====
module ed2_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [63:0] radicand,
  output logic        out_vld,
  output logic [31:0] root
);
  import ed2_pkg::*;

  sq_st_t                 st_r   [SQ_STAGES];
  sq_st_t                 st_nxt [SQ_STAGES];
  logic [SQ_STAGES-1:0]   vld_r;

  // each stage resolves SQ_PER root bits
  always_comb begin
    st_nxt[0] = sq_stage('{rad: radicand, rem: '0, root: '0});
    for (int s = 1; s < SQ_STAGES; s++) begin
      st_nxt[s] = sq_stage(st_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[SQ_STAGES-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[SQ_STAGES-1];
  assign root    = st_r[SQ_STAGES-1].root;

endmodule

// ===== rtl/ed2_div.sv =====
module ed2_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [30:0] num_a,
  input  logic [30:0] num_b,
  input  logic [31:0] divisor,
  output logic        out_vld,
  output logic [30:0] q_a,
  output logic [30:0] q_b
);
  import ed2_pkg::*;

  // computes (num << 30) / divisor for two numerators; quotient fits 31 bits
  // because divisor >= num
  dv_st_t                 st_r   [DV_STAGES];
  dv_st_t                 st_nxt [DV_STAGES];
  logic [DV_STAGES-1:0]   vld_r;
  dv_st_t                 head;

  assign head = '{n: divisor, rem_a: {2'b00, num_a[30:1]}, rem_b: {2'b00, num_b[30:1]},
                  nb_a: num_a[0], nb_b: num_b[0], q_a: '0, q_b: '0};

  always_comb begin
    st_nxt[0] = dv_stage(head, 0);
    for (int s = 1; s < DV_STAGES; s++) begin
      st_nxt[s] = dv_stage(st_r[s-1], s * DV_PER);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DV_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DV_STAGES-2:0], in_vld};
    end
  end

  assign out_vld = vld_r[DV_STAGES-1];
  assign q_a     = st_r[DV_STAGES-1].q_a;
  assign q_b     = st_r[DV_STAGES-1].q_b;

endmodule

// ===== rtl/ed2_vec.sv =====
module ed2_vec (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic signed [31:0] off,
  input  logic signed [34:0] diff,
  input  logic [16:0]        thr,
  output logic               out_vld,
  output logic signed [31:0] comp_a,
  output logic signed [31:0] comp_b
);
  import ed2_pkg::*;

  localparam int FLG_DLY = SQ_STAGES + DV_STAGES;

  // stage 1: magnitudes, pre-shift, flags
  logic [31:0]  u_mag;
  logic [34:0]  v_mag;
  logic [30:0]  us_nxt, vs_nxt;
  logic         hit;
  vec_flags_t   flg_nxt;
  logic         near, both_zero;

  always_comb begin
    u_mag  = off[31] ? 32'(-off) : 32'(off);
    v_mag  = diff[34] ? 35'(-diff) : 35'(diff);
    us_nxt = u_mag[30:0];
    vs_nxt = v_mag[30:0];
    hit    = 1'b0;
    for (int k = 0; k <= 4; k++) begin
      if (!hit && ((35'(u_mag) >> k) < 35'h0_8000_0000) &&
          ((v_mag >> k) < 35'h0_8000_0000)) begin
        us_nxt = 31'(35'(u_mag) >> k);
        vs_nxt = 31'(v_mag >> k);
        hit    = 1'b1;
      end
    end
    near          = v_mag < 35'(thr);
    both_zero     = (us_nxt == '0) && (vs_nxt == '0);
    flg_nxt.axis  = near || both_zero;
    flg_nxt.neg_a = diff[34] ? off[31] : (!off[31] && (off != '0));
  end

  logic [30:0] us1_r, vs1_r;
  vec_flags_t  flg1_r;
  logic [30:0] us2_r, vs2_r;
  vec_flags_t  flg2_r;
  logic [61:0] uu_r, vv_r;
  logic [30:0] us3_r, vs3_r;
  vec_flags_t  flg3_r;
  logic [62:0] ss_r;
  logic [2:0]  vld_r;

  // stages 2 and 3: squares, then their sum
  always_ff @(posedge clk) begin
    if (en) begin
      us1_r  <= us_nxt;
      vs1_r  <= vs_nxt;
      flg1_r <= flg_nxt;
      uu_r   <= us1_r * us1_r;
      vv_r   <= vs1_r * vs1_r;
      us2_r  <= us1_r;
      vs2_r  <= vs1_r;
      flg2_r <= flg1_r;
      ss_r   <= 63'(uu_r) + 63'(vv_r);
      us3_r  <= us2_r;
      vs3_r  <= vs2_r;
      flg3_r <= flg2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_vld};
    end
  end

  // norm
  logic        n_vld;
  logic [31:0] n_root;

  ed2_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[2]),
    .radicand ({1'b0, ss_r}),
    .out_vld  (n_vld),
    .root     (n_root)
  );

  // operands ride alongside the root, flags alongside the root and divider
  logic [30:0] usd_r [SQ_STAGES];
  logic [30:0] vsd_r [SQ_STAGES];
  vec_flags_t  flgd_r [FLG_DLY];

  always_ff @(posedge clk) begin
    if (en) begin
      usd_r[0]  <= us3_r;
      vsd_r[0]  <= vs3_r;
      flgd_r[0] <= flg3_r;
      for (int i = 1; i < SQ_STAGES; i++) begin
        usd_r[i] <= usd_r[i-1];
        vsd_r[i] <= vsd_r[i-1];
      end
      for (int i = 1; i < FLG_DLY; i++) begin
        flgd_r[i] <= flgd_r[i-1];
      end
    end
  end

  logic        q_vld;
  logic [30:0] q_a, q_b;

  ed2_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (n_vld),
    .num_a   (usd_r[SQ_STAGES-1]),
    .num_b   (vsd_r[SQ_STAGES-1]),
    .divisor (n_root),
    .out_vld (q_vld),
    .q_a     (q_a),
    .q_b     (q_b)
  );

  // last stage: clip, sign, axis select
  logic [30:0]        qa_cl, qb_cl;
  vec_flags_t         flg_q;
  logic signed [31:0] comp_a_nxt, comp_b_nxt;
  logic signed [31:0] comp_a_r, comp_b_r;
  logic               out_vld_r;

  always_comb begin
    flg_q = flgd_r[FLG_DLY-1];
    qa_cl = (q_a > ONE_Q30_U) ? ONE_Q30_U : q_a;
    qb_cl = (q_b > ONE_Q30_U) ? ONE_Q30_U : q_b;
    if (flg_q.axis) begin
      comp_a_nxt = ONE_Q30;
      comp_b_nxt = '0;
    end else begin
      comp_a_nxt = flg_q.neg_a ? -$signed(32'(qa_cl)) : $signed(32'(qa_cl));
      comp_b_nxt = $signed(32'(qb_cl));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      comp_a_r <= comp_a_nxt;
      comp_b_r <= comp_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= q_vld;
    end
  end

  assign out_vld = out_vld_r;
  assign comp_a  = comp_a_r;
  assign comp_b  = comp_b_r;

endmodule

// ===== rtl/eigen_decomp_2x2.sv =====
// Closed-form eigendecomposition of one real 2x2 Q16.16 matrix per beat.
// Fully pipelined: a new matrix may enter every cycle unless in_stall is set.
// The delay from each input beat to its result is set by the square root
// units (32 steps, 2 per stage) used once for the discriminant and once per
// eigenvector norm, and the restoring divider (31 quotient bits, 4 per stage).
// A stalled output beat freezes the whole pipeline; in_stall follows it in
// the same cycle. equal_threshold is written through cfg_wr_en/cfg_wr_data
// and must only change while no beats are in flight.
module eigen_decomp_2x2 (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_a00,
  input  logic signed [31:0] in_a01,
  input  logic signed [31:0] in_a10,
  input  logic signed [31:0] in_a11,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_lambda_low,
  output logic signed [31:0] out_lambda_high,
  output logic signed [31:0] out_vec_low_x,
  output logic signed [31:0] out_vec_low_y,
  output logic signed [31:0] out_vec_high_x,
  output logic signed [31:0] out_vec_high_y,
  output logic               out_complex_flag,
  output logic               out_saturated_flag
);
  import ed2_pkg::*;

  typedef struct packed {
    logic signed [31:0] a00;
    logic signed [31:0] a01;
    logic signed [31:0] a10;
    logic signed [31:0] a11;
    logic signed [32:0] sum;
    logic               cplx;
  } ctx_t;

  typedef struct packed {
    logic signed [31:0] lam_lo;
    logic signed [31:0] lam_hi;
    logic               sat;
    logic               cplx;
  } lam_t;

  logic        en;
  logic        out_valid_r;
  logic [16:0] thr_r;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_wr_en) begin
      thr_r <= cfg_wr_data;
    end
  end

  // stage 1: diagonal difference magnitude and trace
  logic signed [32:0] dsub;
  logic [32:0]        du_nxt;
  ctx_t               c1_nxt, c1_r, c2_r;
  logic [32:0]        du_r;
  logic [65:0]        du2_r;
  logic signed [63:0] prod_r;
  logic [2:0]         vld_r;

  always_comb begin
    dsub       = {in_a00[31], in_a00} - {in_a11[31], in_a11};
    du_nxt     = dsub[32] ? 33'(-dsub) : 33'(dsub);
    c1_nxt.a00 = in_a00;
    c1_nxt.a01 = in_a01;
    c1_nxt.a10 = in_a10;
    c1_nxt.a11 = in_a11;
    c1_nxt.sum = {in_a00[31], in_a00} + {in_a11[31], in_a11};
    c1_nxt.cplx = 1'b0;
  end

  // stage 3: discriminant over four, sign check
  logic signed [65:0] x_val;
  ctx_t               c3_nxt, c3_r;
  logic [63:0]        rad_r;

  always_comb begin
    x_val       = $signed({2'b00, du2_r[65:2]}) + $signed({{2{prod_r[63]}}, prod_r});
    c3_nxt      = c2_r;
    c3_nxt.cplx = x_val[65];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r   <= c1_nxt;
      du_r   <= du_nxt;
      du2_r  <= du_r * du_r;
      prod_r <= c1_r.a01 * c1_r.a10;
      c2_r   <= c1_r;
      c3_r   <= c3_nxt;
      rad_r  <= x_val[65] ? 64'd0 : x_val[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[1:0], in_valid};
    end
  end

  // half of delta
  logic        h_vld;
  logic [31:0] h_root;
  ctx_t        cd_r [SQ_STAGES];

  ed2_isqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_r[2]),
    .radicand (rad_r),
    .out_vld  (h_vld),
    .root     (h_root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= c3_r;
      for (int i = 1; i < SQ_STAGES; i++) begin
        cd_r[i] <= cd_r[i-1];
      end
    end
  end

  // stage 4: eigenvalues, saturation, diagonal differences
  ctx_t               ch;
  logic signed [33:0] lo, hi;
  logic signed [34:0] d0_nxt, d1_nxt;
  lam_t               lam_nxt, lam_r;
  logic signed [34:0] d0_r, d1_r;
  logic signed [31:0] a01_r, a10_r;
  logic               t4_vld_r;

  always_comb begin
    ch              = cd_r[SQ_STAGES-1];
    lo              = $signed({ch.sum[32], ch.sum[32:1]}) - $signed({2'b00, h_root});
    hi              = $signed({ch.sum[32], ch.sum[32:1]}) + $signed({2'b00, h_root});
    d0_nxt          = $signed({{3{ch.a00[31]}}, ch.a00}) - $signed({lo[33], lo});
    d1_nxt          = $signed({{3{ch.a11[31]}}, ch.a11}) - $signed({hi[33], hi});
    lam_nxt.cplx    = ch.cplx;
    lam_nxt.sat     = 1'b0;
    lam_nxt.lam_lo  = lo[31:0];
    lam_nxt.lam_hi  = hi[31:0];
    if (lo[33:31] != 3'b000 && lo[33:31] != 3'b111) begin
      lam_nxt.sat    = 1'b1;
      lam_nxt.lam_lo = lo[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    if (hi[33:31] != 3'b000 && hi[33:31] != 3'b111) begin
      lam_nxt.sat    = 1'b1;
      lam_nxt.lam_hi = hi[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lam_r <= lam_nxt;
      d0_r  <= d0_nxt;
      d1_r  <= d1_nxt;
      a01_r <= ch.a01;
      a10_r <= ch.a10;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t4_vld_r <= 1'b0;
    end else if (en) begin
      t4_vld_r <= h_vld;
    end
  end

  // eigenvectors
  logic               vl_vld, vh_vld;
  logic signed [31:0] vl_a, vl_b, vh_a, vh_b;

  ed2_vec u_vec_low (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (t4_vld_r),
    .off     (a01_r),
    .diff    (d0_r),
    .thr     (thr_r),
    .out_vld (vl_vld),
    .comp_a  (vl_a),
    .comp_b  (vl_b)
  );

  ed2_vec u_vec_high (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (t4_vld_r),
    .off     (a10_r),
    .diff    (d1_r),
    .thr     (thr_r),
    .out_vld (vh_vld),
    .comp_a  (vh_a),
    .comp_b  (vh_b)
  );

  lam_t lamd_r [VEC_LAT];

  always_ff @(posedge clk) begin
    if (en) begin
      lamd_r[0] <= lam_r;
      for (int i = 1; i < VEC_LAT; i++) begin
        lamd_r[i] <= lamd_r[i-1];
      end
    end
  end

  // output register; complex case zeroes everything but the flag
  lam_t               lq;
  logic signed [31:0] lam_lo_r, lam_hi_r, vlx_r, vly_r, vhx_r, vhy_r;
  logic               cplx_r, sat_r;

  assign lq = lamd_r[VEC_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      cplx_r <= lq.cplx;
      if (lq.cplx) begin
        lam_lo_r <= '0;
        lam_hi_r <= '0;
        vlx_r    <= '0;
        vly_r    <= '0;
        vhx_r    <= '0;
        vhy_r    <= '0;
        sat_r    <= 1'b0;
      end else begin
        lam_lo_r <= lq.lam_lo;
        lam_hi_r <= lq.lam_hi;
        vlx_r    <= vl_a;
        vly_r    <= vl_b;
        vhx_r    <= vh_b;
        vhy_r    <= vh_a;
        sat_r    <= lq.sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vl_vld;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_lambda_low     = lam_lo_r;
  assign out_lambda_high    = lam_hi_r;
  assign out_vec_low_x      = vlx_r;
  assign out_vec_low_y      = vly_r;
  assign out_vec_high_x     = vhx_r;
  assign out_vec_high_y     = vhy_r;
  assign out_complex_flag   = cplx_r;
  assign out_saturated_flag = sat_r;

  // both vector units must stay in lockstep
  a_vec_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    vl_vld == vh_vld)
    else $error("eigenvector units out of step");

  a_complex_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cplx_r |-> lam_lo_r == 0 && lam_hi_r == 0 && vlx_r == 0 &&
      vly_r == 0 && vhx_r == 0 && vhy_r == 0 && !sat_r)
    else $error("complex result not cleared");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cplx_r |-> lam_lo_r <= lam_hi_r)
    else $error("eigenvalues out of order");

  a_diag_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !cplx_r |-> vly_r >= 0 && vly_r <= ONE_Q30 &&
      vhx_r >= 0 && vhx_r <= ONE_Q30)
    else $error("diagonal-side component out of range");

endmodule

// ===== verif/eigen_checker.sv =====
`timescale 1ns / 100ps

module eigen_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [16:0]        cfg_wr_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [31:0] in_a00,
  input  logic signed [31:0] in_a01,
  input  logic signed [31:0] in_a10,
  input  logic signed [31:0] in_a11,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [31:0] out_lambda_low,
  input  logic signed [31:0] out_lambda_high,
  input  logic signed [31:0] out_vec_low_x,
  input  logic signed [31:0] out_vec_low_y,
  input  logic signed [31:0] out_vec_high_x,
  input  logic signed [31:0] out_vec_high_y,
  input  logic               out_complex_flag,
  input  logic               out_saturated_flag,
  output int                 fail_count,
  output int                 pending
);

  typedef struct {
    logic signed [31:0] lam_lo;
    logic signed [31:0] lam_hi;
    logic signed [31:0] vlx;
    logic signed [31:0] vly;
    logic signed [31:0] vhx;
    logic signed [31:0] vhy;
    logic               cplx;
    logic               sat;
  } eig_t;

  eig_t      eig_q[$];
  logic [16:0] thr;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs64(input longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // normalized (-sign*off, |d|); returns 0 when both parts vanish
  function automatic bit unit_vec(input longint off, input longint d,
                                  output longint pa, output longint pb);
    logic [63:0] u;
    logic [63:0] v;
    logic [63:0] n;
    logic [63:0] qa;
    logic [63:0] qb;
    int          k;
    bit          neg;
    u = abs64(off);
    v = abs64(d);
    k = 0;
    while (k < 40 && ((u >> k) >= 64'h8000_0000 || (v >> k) >= 64'h8000_0000)) k++;
    u = u >> k;
    v = v >> k;
    pa = 0;
    pb = 0;
    if (u == 0 && v == 0) return 0;
    n = int_sqrt(u * u + v * v);
    if (n == 0) return 0;
    qa = (u << 30) / n;
    qb = (v << 30) / n;
    if (qa > 64'h4000_0000) qa = 64'h4000_0000;
    if (qb > 64'h4000_0000) qb = 64'h4000_0000;
    neg = (d < 0) ? (off < 0) : (off > 0);
    pa = neg ? -longint'(qa) : longint'(qa);
    pb = longint'(qb);
    return 1;
  endfunction

  function automatic longint clamp32(input longint v, inout logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic eig_t eigen_solve(input longint a00, input longint a01,
                                       input longint a10, input longint a11,
                                       input logic [16:0] t);
    eig_t        e;
    logic [63:0] du;
    longint      x;
    longint      h;
    longint      mid;
    longint      lo;
    longint      hi;
    longint      d0;
    longint      d1;
    longint      p;
    longint      q;
    logic        sat;
    e = '{default: 0};
    du = abs64(a00 - a11);
    x = longint'((du * du) >> 2) + a01 * a10;
    if (x < 0) begin
      e.cplx = 1;
      return e;
    end
    h = longint'(int_sqrt(64'(x)));
    mid = ((a00 + a11) >>> 1);
    lo = mid - h;
    hi = mid + h;
    e.vlx = 32'sh4000_0000;
    e.vhy = 32'sh4000_0000;
    d0 = a00 - lo;
    if (abs64(d0) >= t && unit_vec(a01, d0, p, q)) begin
      e.vlx = p[31:0];
      e.vly = q[31:0];
    end
    d1 = a11 - hi;
    if (abs64(d1) >= t && unit_vec(a10, d1, p, q)) begin
      e.vhy = p[31:0];
      e.vhx = q[31:0];
    end
    sat = 0;
    e.lam_lo = 32'(clamp32(lo, sat));
    e.lam_hi = 32'(clamp32(hi, sat));
    e.sat = sat;
    return e;
  endfunction

  task automatic cmp(input string name, input logic [31:0] exp_v,
                     input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  assign pending = eig_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    eig_t e;
    if (!rst_n) begin
      thr <= ed2_pkg::THR_RESET;
    end else begin
      if (cfg_wr_en) thr <= cfg_wr_data;
      // input beat
      if (in_valid && !in_stall)
        eig_q.push_back(eigen_solve(in_a00, in_a01, in_a10, in_a11, thr));
      // result beat
      if (out_valid && !out_stall) begin
        if (eig_q.size() == 0) begin
          $error("result beat with nothing expected");
          fail_count++;
        end else begin
          e = eig_q.pop_front();
          cmp("lambda_low", e.lam_lo, out_lambda_low);
          cmp("lambda_high", e.lam_hi, out_lambda_high);
          cmp("vec_low_x", e.vlx, out_vec_low_x);
          cmp("vec_low_y", e.vly, out_vec_low_y);
          cmp("vec_high_x", e.vhx, out_vec_high_x);
          cmp("vec_high_y", e.vhy, out_vec_high_y);
          cmp("complex_flag", e.cplx, out_complex_flag);
          cmp("saturated_flag", e.sat, out_saturated_flag);
        end
      end
    end
  end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

  logic               clk;
  logic               rst_n;
  logic               cfg_wr_en;
  logic [16:0]        cfg_wr_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_a00;
  logic signed [31:0] in_a01;
  logic signed [31:0] in_a10;
  logic signed [31:0] in_a11;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_lambda_low;
  logic signed [31:0] out_lambda_high;
  logic signed [31:0] out_vec_low_x;
  logic signed [31:0] out_vec_low_y;
  logic signed [31:0] out_vec_high_x;
  logic signed [31:0] out_vec_high_y;
  logic               out_complex_flag;
  logic               out_saturated_flag;
  int                 fail_count;
  int                 pending;
  bit                 stim_done;

  localparam int PIPE_LAT = 49;

  eigen_decomp_2x2 dut (.*);

  eigen_checker chk (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // result side stall: random wait per beat, with calm stretches
  initial begin
    int w;
    out_stall = 1;
    @(posedge clk);
    forever begin
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stim_done && $urandom_range(0, 1)) w = 0;
      repeat (w) begin
        out_stall <= 1;
        @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // drive one matrix beat, after a random gap unless no_gap is set
  task automatic send_matrix(input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] c, input logic [31:0] d,
                             input bit no_gap);
    int w;
    w = no_gap ? 0 : $urandom_range(0, 13);
    if (w > 0) begin
      in_valid <= 0;
      repeat (w) @(posedge clk);
    end
    in_valid <= 1;
    in_a00 <= a;
    in_a01 <= b;
    in_a10 <= c;
    in_a11 <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_LAT + 5) @(posedge clk);
  endtask

  task automatic set_thr(input logic [16:0] v);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
  endtask

  function automatic logic [31:0] rnd_entry();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
      3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom())};
      default: return 32'($signed($urandom_range(0, 64)) - 32) << 14;
    endcase
  endfunction

  task automatic random_phase(input int n);
    logic [31:0] a, b, c, d;
    bit          burst;
    for (int i = 0; i < n; i++) begin
      a = rnd_entry();
      b = rnd_entry();
      c = rnd_entry();
      d = rnd_entry();
      case ($urandom_range(0, 7))
        0: d = a;                            // equal diagonal
        1: c = 0;                            // triangular
        2: c = b;                            // symmetric
        3: d = a + $urandom_range(0, 3);     // near-equal diagonal
        default: ;
      endcase
      burst = ($urandom_range(0, 3) == 0);
      send_matrix(a, b, c, d, burst);
    end
  endtask

  initial begin
    logic [31:0] ext[4];
    stim_done = 0;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_wr_data = 0;
    in_valid = 0;
    in_a00 = 0;
    in_a01 = 0;
    in_a10 = 0;
    in_a11 = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, complex, saturation, zero, diagonal, triangular
    ext = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h0001_0000};
    send_matrix(0, 0, 0, 0, 0);
    send_matrix(32'h0001_0000, 0, 0, 32'h0001_0000, 0);
    send_matrix(32'h0002_0000, 0, 0, 32'h0001_0000, 0);
    send_matrix(0, 32'h0001_0000, 32'hffff_0000, 0, 0);   // rotation: complex
    send_matrix(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0);
    send_matrix(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_matrix(32'h7fff_ffff, 32'h0, 32'h0, 32'h8000_0000, 1);
    send_matrix(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0);
    send_matrix(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0004_0000, 0);
    send_matrix(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0001_0000, 0);
    send_matrix(32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0002_0000, 0);
    for (int i = 0; i < 8; i++)
      send_matrix(ext[i % 4], ext[(i + 1) % 4], ext[(i + 2) % 4], ext[(i + 3) % 4], 0);
    drain();

    // threshold zero: exact-zero difference counts as positive
    set_thr(0);
    send_matrix(32'h0001_0000, 32'hffff_0000, 32'h0, 32'h0001_0000, 0);
    send_matrix(32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0001_0000, 0);
    send_matrix(32'h0001_0000, 32'h0, 32'hffff_0000, 32'h0001_0000, 0);
    send_matrix(32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0001_0000, 0);
    random_phase(150);
    drain();

    set_thr(17'h1_0000);
    random_phase(150);
    drain();

    set_thr(17'($urandom_range(0, 17'h1_ffff)));
    random_phase(150);
    drain();

    set_thr(17'h1_ffff);
    random_phase(80);
    drain();

    set_thr(1);
    random_phase(100);
    drain();
    stim_done = 1;

    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ed2_pkg.sv
rtl/ed2_isqrt.sv
rtl/ed2_div.sv
rtl/ed2_vec.sv
rtl/eigen_decomp_2x2.sv
verif/eigen_checker.sv
verif/tb.sv
